[rtl/core/dceq_pkg.sv]
// ----------------------------------------------------------------------------
// dceq_pkg
// Shared constants, types and helpers for the dual contouring quad core.
// ----------------------------------------------------------------------------
package dceq_pkg;

  // Grid geometry
  localparam int MAX_NODES = 256;
  localparam int MIN_NODES = 3;
  localparam int POS_W     = $clog2(MAX_NODES);
  localparam int SIZE_W    = POS_W + 1;
  localparam int ADDR_W    = 2 * POS_W;
  localparam int MEM_DEPTH = MAX_NODES * MAX_NODES;

  // Field widths
  localparam int IDX_W     = 24;
  localparam int PHI_W     = 24;
  localparam int AXIS_W    = 2;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  // Group queue sizing
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int INFL_W     = 2;
  localparam int NUM_AXES   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_Z = CFG_IDX_W'(2);

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Effective grid sizes
  typedef struct packed {
    logic [SIZE_W-1:0] nx;
    logic [SIZE_W-1:0] ny;
    logic [SIZE_W-1:0] nz;
  } dims_t;

  // All quads of one node: base cell index, stride offsets, enables, orientation
  typedef struct packed {
    logic [IDX_W-1:0]    base;
    logic [ADDR_W-1:0]   xs;
    logic [ADDR_W-1:0]   xs1;
    logic [ADDR_W-1:0]   zs;
    logic [ADDR_W-1:0]   zs1;
    logic [ADDR_W-1:0]   xz;
    logic [ADDR_W-1:0]   xz1;
    logic [NUM_AXES-1:0] en;
    logic [NUM_AXES-1:0] dir;
  } group_t;

  // Clamp a programmed size into the supported range
  function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (int'(v) < MIN_NODES) begin
      r = SIZE_W'(MIN_NODES);
    end else if (int'(v) > MAX_NODES) begin
      r = SIZE_W'(MAX_NODES);
    end else begin
      r = SIZE_W'(v);
    end
    return r;
  endfunction

endpackage

[rtl/core/dceq_plane_pipe.sv]
// ----------------------------------------------------------------------------
// dceq_plane_pipe
// Position tracking, sign plane memory and the three stage pipeline that
// turns one node into a group of up to three oriented quads.
// ----------------------------------------------------------------------------
module dceq_plane_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dceq_pkg::dims_t                  dims,
  input  logic                             acc,
  input  logic signed [dceq_pkg::PHI_W-1:0] phi,
  input  logic                             vol_start,
  output logic                             grp_push,
  output dceq_pkg::group_t                 grp,
  output logic [dceq_pkg::INFL_W-1:0]      inflight
);

  localparam int POS_W  = dceq_pkg::POS_W;
  localparam int SIZE_W = dceq_pkg::SIZE_W;
  localparam int ADDR_W = dceq_pkg::ADDR_W;
  localparam int IDX_W  = dceq_pkg::IDX_W;
  localparam int NAX    = dceq_pkg::NUM_AXES;

  // Position counters and previous node sign
  logic [POS_W-1:0]  pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0]  pos_x_nxt, pos_y_nxt, pos_z_nxt;
  logic [POS_W-1:0]  x0, y0, z0;
  logic [SIZE_W-1:0] x_inc, y_inc, z_inc;
  logic              prev_r;
  logic              cur_in;

  // Stage valids
  logic s1_v_r, s2_v_r, s3_v_r;

  // Stage 1 payload
  logic [POS_W-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic             s1_cur_r, s1_prv_r;

  // Stage 1 logic
  logic [POS_W+SIZE_W-1:0] yn_prod;
  logic [ADDR_W-1:0]       addr1, addr_up;
  logic [POS_W-1:0]        zs1c, ys1c;
  logic [ADDR_W-1:0]       xs1c, yzs1c;
  logic [SIZE_W-1:0]       xe, ye, ze;
  logic [NAX-1:0]          edge1;

  // Stage 2 payload
  logic [POS_W-1:0]  s2_x_r, s2_z_r, s2_zs_r;
  logic [ADDR_W-1:0] s2_xs_r, s2_yzs_r, s2_addr_r;
  logic              s2_cur_r, s2_prv_r;
  logic [NAX-1:0]    s2_edge_r;
  logic              rd_x_r, rd_y_r;
  logic              fwd_x_r, fwd_y_r, fwd_val_r;

  // Stage 2 logic
  logic                    low_x, low_y;
  logic [NAX-1:0]          en2, dir2;
  logic [POS_W+ADDR_W-1:0] xm_full;
  logic [ADDR_W:0]         part2;
  logic [ADDR_W-1:0]       xz2;

  // Stage 3 payload
  logic [IDX_W-1:0]  s3_xm_r;
  logic [ADDR_W:0]   s3_part_r;
  logic [ADDR_W-1:0] s3_xs_r, s3_xz_r;
  logic [POS_W-1:0]  s3_zs_r;
  logic [NAX-1:0]    s3_en_r, s3_dir_r;

  // Sign plane: one inside bit per (y, z)
  logic sign_mem [dceq_pkg::MEM_DEPTH];

  // Inside test: phi at most zero
  assign cur_in = (phi == '0) || phi[dceq_pkg::PHI_W-1];

  // Advance position, restarting on a new volume
  always_comb begin
    x0 = vol_start ? '0 : pos_x_r;
    y0 = vol_start ? '0 : pos_y_r;
    z0 = vol_start ? '0 : pos_z_r;
    x_inc = {1'b0, x0} + SIZE_W'(1);
    y_inc = {1'b0, y0} + SIZE_W'(1);
    z_inc = {1'b0, z0} + SIZE_W'(1);
    pos_x_nxt = x0;
    pos_y_nxt = y0;
    pos_z_nxt = z_inc[POS_W-1:0];
    if (z_inc >= dims.nz) begin
      pos_z_nxt = '0;
      pos_y_nxt = y_inc[POS_W-1:0];
      if (y_inc >= dims.ny) begin
        pos_y_nxt = '0;
        pos_x_nxt = x_inc[POS_W-1:0];
        if (x_inc >= dims.nx) begin
          pos_x_nxt = '0;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
      prev_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
    end else begin
      if (acc) begin
        pos_x_r <= pos_x_nxt;
        pos_y_r <= pos_y_nxt;
        pos_z_r <= pos_z_nxt;
        prev_r  <= cur_in;
      end
      s1_v_r <= acc;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Capture the accepted node
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x_r   <= x0;
      s1_y_r   <= y0;
      s1_z_r   <= z0;
      s1_cur_r <= cur_in;
      s1_prv_r <= prev_r;
    end
  end

  // Stage 1: plane addresses, strides and edge qualification
  always_comb begin
    zs1c    = dims.nz[POS_W-1:0] - POS_W'(1);
    ys1c    = dims.ny[POS_W-1:0] - POS_W'(1);
    yn_prod = {{SIZE_W{1'b0}}, s1_y_r} * {{POS_W{1'b0}}, dims.nz};
    addr1   = ADDR_W'(yn_prod + {{SIZE_W{1'b0}}, s1_z_r});
    addr_up = addr1 - ADDR_W'(dims.nz);
    xs1c    = {{POS_W{1'b0}}, ys1c} * {{POS_W{1'b0}}, zs1c};
    yzs1c   = {{POS_W{1'b0}}, s1_y_r} * {{POS_W{1'b0}}, zs1c};
    xe = {1'b0, s1_x_r};
    ye = {1'b0, s1_y_r};
    ze = {1'b0, s1_z_r};
    edge1[0] = (xe != '0) && (xe <= dims.nx - SIZE_W'(1)) &&
               (ye != '0) && (ye <= dims.ny - SIZE_W'(2)) &&
               (ze != '0) && (ze <= dims.nz - SIZE_W'(2));
    edge1[1] = (xe != '0) && (xe <= dims.nx - SIZE_W'(2)) &&
               (ye != '0) && (ye <= dims.ny - SIZE_W'(1)) &&
               (ze != '0) && (ze <= dims.nz - SIZE_W'(2));
    edge1[2] = (xe != '0) && (xe <= dims.nx - SIZE_W'(2)) &&
               (ye != '0) && (ye <= dims.ny - SIZE_W'(2)) &&
               (ze != '0) && (ze <= dims.nz - SIZE_W'(1));
  end

  // Read both neighbors, write back the node in stage 2
  always_ff @(posedge clk) begin
    if (s2_v_r) begin
      sign_mem[s2_addr_r] <= s2_cur_r;
    end
    rd_x_r <= sign_mem[addr1];
    rd_y_r <= sign_mem[addr_up];
  end

  // Forward the write that lands on the same plane address as a read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_x_r <= 1'b0;
      fwd_y_r <= 1'b0;
    end else begin
      fwd_x_r <= s2_v_r && (s2_addr_r == addr1);
      fwd_y_r <= s2_v_r && (s2_addr_r == addr_up);
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk) begin
    fwd_val_r <= s2_cur_r;
    s2_x_r    <= s1_x_r;
    s2_z_r    <= s1_z_r;
    s2_zs_r   <= zs1c;
    s2_xs_r   <= xs1c;
    s2_yzs_r  <= yzs1c;
    s2_addr_r <= addr1;
    s2_cur_r  <= s1_cur_r;
    s2_prv_r  <= s1_prv_r;
    s2_edge_r <= edge1;
  end

  // Stage 2: sign change per edge, x plane offset
  always_comb begin
    low_x   = fwd_x_r ? fwd_val_r : rd_x_r;
    low_y   = fwd_y_r ? fwd_val_r : rd_y_r;
    dir2    = {s2_prv_r, low_y, low_x};
    en2     = s2_edge_r & (dir2 ^ {NAX{s2_cur_r}});
    xm_full = {{ADDR_W{1'b0}}, s2_x_r} * {{POS_W{1'b0}}, s2_xs_r};
    part2   = {1'b0, s2_yzs_r} + {{(ADDR_W + 1 - POS_W){1'b0}}, s2_z_r};
    xz2     = s2_xs_r + {{POS_W{1'b0}}, s2_zs_r};
  end

  always_ff @(posedge clk) begin
    s3_xm_r   <= IDX_W'(xm_full);
    s3_part_r <= part2;
    s3_xs_r   <= s2_xs_r;
    s3_zs_r   <= s2_zs_r;
    s3_xz_r   <= xz2;
    s3_en_r   <= en2;
    s3_dir_r  <= dir2;
  end

  // Stage 3: base cell index and corner offsets
  always_comb begin
    grp.base = s3_xm_r + IDX_W'(s3_part_r);
    grp.xs   = s3_xs_r;
    grp.xs1  = s3_xs_r + ADDR_W'(1);
    grp.zs   = {{POS_W{1'b0}}, s3_zs_r};
    grp.zs1  = {{POS_W{1'b0}}, s3_zs_r} + ADDR_W'(1);
    grp.xz   = s3_xz_r;
    grp.xz1  = s3_xz_r + ADDR_W'(1);
    grp.en   = s3_en_r;
    grp.dir  = s3_dir_r;
  end

  // Drop nodes that produce no quad
  assign grp_push = s3_v_r && (s3_en_r != '0);
  assign inflight = {1'b0, s1_v_r} + {1'b0, s2_v_r} + {1'b0, s3_v_r};

endmodule

[rtl/core/dceq_group_fifo.sv]
// ----------------------------------------------------------------------------
// dceq_group_fifo
// Small queue of per-node quad groups between the pipeline and the output.
// ----------------------------------------------------------------------------
module dceq_group_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  dceq_pkg::group_t                  push_data,
  input  logic                              pop,
  output dceq_pkg::group_t                  head,
  output logic                              head_valid,
  output logic [dceq_pkg::FIFO_CNT_W-1:0]   count
);

  localparam int PTR_W = dceq_pkg::FIFO_PTR_W;
  localparam int CNT_W = dceq_pkg::FIFO_CNT_W;

  dceq_pkg::group_t q_mem [dceq_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Occupancy update
  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Store incoming group
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  assign head       = q_mem[rd_ptr_r];
  assign head_valid = (cnt_r != '0);
  assign count      = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CNT_W'(dceq_pkg::FIFO_DEPTH))
    else $error("group queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("group queue underflow");

endmodule

[rtl/core/dceq_quad_emit.sv]
// ----------------------------------------------------------------------------
// dceq_quad_emit
// Walks the enabled axes of the head group and loads one quad per
// transaction into the output register.
// ----------------------------------------------------------------------------
module dceq_quad_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dceq_pkg::group_t              head,
  input  logic                          head_valid,
  output logic                          pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [dceq_pkg::IDX_W-1:0]    corner_first,
  output logic [dceq_pkg::IDX_W-1:0]    corner_second,
  output logic [dceq_pkg::IDX_W-1:0]    corner_third,
  output logic [dceq_pkg::IDX_W-1:0]    corner_fourth,
  output logic [dceq_pkg::AXIS_W-1:0]   edge_axis,
  output logic                          last_of_run
);

  localparam int IDX_W  = dceq_pkg::IDX_W;
  localparam int ADDR_W = dceq_pkg::ADDR_W;
  localparam int NAX    = dceq_pkg::NUM_AXES;

  logic [NAX-1:0]    done_r, pend, sel;
  logic              last, load, d;
  dceq_pkg::axis_t   axis;
  logic [ADDR_W-1:0] o0, o1, o2, o3;
  logic              out_valid_r;
  logic [IDX_W-1:0]  c0_r, c1_r, c2_r, c3_r;
  dceq_pkg::axis_t   axis_r;
  logic              last_r;

  // Pick the next pending axis in x, y, z order
  always_comb begin
    pend = head.en & ~done_r;
    if (pend[0]) begin
      sel  = 3'b001;
      axis = dceq_pkg::AXIS_X;
    end else if (pend[1]) begin
      sel  = 3'b010;
      axis = dceq_pkg::AXIS_Y;
    end else begin
      sel  = 3'b100;
      axis = dceq_pkg::AXIS_Z;
    end
    last = ((pend & ~sel) == '0);
    load = head_valid && (!out_valid_r || out_ready);
    pop  = load && last;
  end

  // Corner offsets below the base index, by axis and orientation
  always_comb begin
    d  = |(head.dir & sel);
    o0 = '0;
    o1 = '0;
    o2 = '0;
    o3 = '0;
    case (axis)
      dceq_pkg::AXIS_X: begin
        o0 = d ? head.xz1 : head.xz;
        o1 = d ? head.xs1 : head.xs;
        o2 = d ? head.xs  : head.xs1;
        o3 = d ? head.xz  : head.xz1;
      end
      dceq_pkg::AXIS_Y: begin
        o0 = d ? head.xz1 : head.zs1;
        o1 = d ? head.xz  : head.zs;
        o2 = d ? head.zs  : head.xz;
        o3 = d ? head.zs1 : head.xz1;
      end
      dceq_pkg::AXIS_Z: begin
        o0 = d ? head.xz1 : head.xs1;
        o1 = d ? head.zs1 : ADDR_W'(1);
        o2 = d ? ADDR_W'(1) : head.zs1;
        o3 = d ? head.xs1 : head.xz1;
      end
      default: begin
        o0 = '0;
      end
    endcase
  end

  // Output register and progress through the head group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      done_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        done_r      <= last ? '0 : (done_r | sel);
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c0_r   <= head.base - {{(IDX_W - ADDR_W){1'b0}}, o0};
      c1_r   <= head.base - {{(IDX_W - ADDR_W){1'b0}}, o1};
      c2_r   <= head.base - {{(IDX_W - ADDR_W){1'b0}}, o2};
      c3_r   <= head.base - {{(IDX_W - ADDR_W){1'b0}}, o3};
      axis_r <= axis;
      last_r <= last;
    end
  end

  assign out_valid     = out_valid_r;
  assign corner_first  = c0_r;
  assign corner_second = c1_r;
  assign corner_third  = c2_r;
  assign corner_fourth = c3_r;
  assign edge_axis     = axis_r;
  assign last_of_run   = last_r;

endmodule

[rtl/core/dual_contour_edge_quads_core.sv]
// ----------------------------------------------------------------------------
// dual_contour_edge_quads_core: dual contouring quad topology over a streamed grid
// Path: stage 1, 2 and 3 registers, group queue, output register. Throughput: one
// node per cycle while in_ready holds, one quad per cycle while out_ready holds; a node
// with three quads sends them one after another on the single result channel.
// Reset: control and positions clear, sizes go to 256, sign plane is not cleared.
// ----------------------------------------------------------------------------
module dual_contour_edge_quads_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dceq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dceq_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [dceq_pkg::PHI_W-1:0]   in_phi_sample,
  input  logic                                in_volume_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dceq_pkg::IDX_W-1:0]          out_corner_first,
  output logic [dceq_pkg::IDX_W-1:0]          out_corner_second,
  output logic [dceq_pkg::IDX_W-1:0]          out_corner_third,
  output logic [dceq_pkg::IDX_W-1:0]          out_corner_fourth,
  output logic [dceq_pkg::AXIS_W-1:0]         out_edge_axis,
  output logic                                out_last_of_run
);

  localparam int CNT_W = dceq_pkg::FIFO_CNT_W;

  logic [dceq_pkg::CFG_W-1:0]  nodes_x_r, nodes_y_r, nodes_z_r;
  dceq_pkg::dims_t             dims;
  logic                        acc;
  logic                        grp_push, head_valid, pop;
  dceq_pkg::group_t            grp, head;
  logic [dceq_pkg::INFL_W-1:0] inflight;
  logic [CNT_W-1:0]            fifo_cnt, credit_used;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_x_r <= dceq_pkg::CFG_W'(dceq_pkg::MAX_NODES);
      nodes_y_r <= dceq_pkg::CFG_W'(dceq_pkg::MAX_NODES);
      nodes_z_r <= dceq_pkg::CFG_W'(dceq_pkg::MAX_NODES);
    end else if (cfg_we) begin
      case (cfg_index)
        dceq_pkg::CFG_NODES_X: nodes_x_r <= cfg_wdata;
        dceq_pkg::CFG_NODES_Y: nodes_y_r <= cfg_wdata;
        dceq_pkg::CFG_NODES_Z: nodes_z_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Clamp sizes into the supported range
  always_comb begin
    dims.nx = dceq_pkg::eff_size(nodes_x_r);
    dims.ny = dceq_pkg::eff_size(nodes_y_r);
    dims.nz = dceq_pkg::eff_size(nodes_z_r);
  end

  // Accept while every node in flight is sure of a queue slot
  assign credit_used = fifo_cnt + {{(CNT_W - dceq_pkg::INFL_W){1'b0}}, inflight};
  assign in_ready    = (credit_used < CNT_W'(dceq_pkg::FIFO_DEPTH));
  assign acc         = in_valid && in_ready;

  dceq_plane_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .acc       (acc),
    .phi       (in_phi_sample),
    .vol_start (in_volume_start),
    .grp_push  (grp_push),
    .grp       (grp),
    .inflight  (inflight)
  );

  dceq_group_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (grp_push),
    .push_data  (grp),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .count      (fifo_cnt)
  );

  dceq_quad_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .head_valid    (head_valid),
    .pop           (pop),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .corner_first  (out_corner_first),
    .corner_second (out_corner_second),
    .corner_third  (out_corner_third),
    .corner_fourth (out_corner_fourth),
    .edge_axis     (out_edge_axis),
    .last_of_run   (out_last_of_run)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= CNT_W'(dceq_pkg::FIFO_DEPTH))
    else $error("nodes in flight exceed queue space");

  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> inflight != '0)
    else $error("accepted transaction not tracked in pipeline");

endmodule
